FILE: src/ppt_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and register codes for the projective point transform.
// No dependencies; every other file in src uses it by scoped names.
package ppt_pkg;

	// Default number of fraction bits in the Q format.
	localparam int FRAC_BITS_DEF = 16;

	// Coordinate and coefficient width.
	localparam int COORD_W = 32;

	// Exact width of c0*x + c1*y + (c2 << F), signed.
	localparam int NUM_W = 2 * COORD_W + 2;

	// Quotient bits produced by the divider; one above the 32-bit range,
	// and anything at or beyond 2^33 is caught by the overflow check.
	localparam int Q_W = COORD_W + 1;

	// Divider latency: magnitude stage, dividend stage, one stage per
	// quotient bit and a rounding stage.
	localparam int DIV_LAT = Q_W + 3;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_M00            = 4'd0,
		REG_M01            = 4'd1,
		REG_M02            = 4'd2,
		REG_M10            = 4'd3,
		REG_M11            = 4'd4,
		REG_M12            = 4'd5,
		REG_PERSPECTIVE_XY = 4'd6,
		REG_M22            = 4'd7
	} cfg_reg_t;

	// Command codes.
	localparam logic CMD_AFFINE     = 1'b0;
	localparam logic CMD_PROJECTIVE = 1'b1;

	// Input transaction payload.
	typedef struct packed {
		logic                      cmd;
		logic signed [COORD_W-1:0] x_in;
		logic signed [COORD_W-1:0] y_in;
	} in_item_t;

	// Output transaction payload.
	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
		logic                      div_by_zero;
		logic                      saturated;
	} out_item_t;

	// Rounded quotient magnitude with its sign and overflow status.
	typedef struct packed {
		logic           neg;
		logic           ovf;
		logic [Q_W:0]   quo;
	} div_res_t;

endpackage

FILE: src/projective_point_transform_core.sv
`timescale 1ns / 1ps
// Top level of the 3x3 projective point transform: config registers, pipeline control.
// Depends on ppt_pkg, ppt_lin and ppt_div.
//
// Usage:
// Points arrive on the in channel (in_valid/in_ready/in_data), one transaction
// per point, and results leave on the out channel (out_valid/out_ready/out_data)
// in the same order, one result per point. The matrix is written through the
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data); cfg_ready is always high
// and writes should happen only while no point is in flight. Unknown indexes
// are ignored.
// Throughput is one point per clock while the output does not stall. For a point
// taken straight into the pipeline the accepting edge loads the products; the sums,
// the divider stages (magnitudes, dividend, one per quotient bit, rounding) and the
// output register follow in that order. Affine points go through the same divider
// with a denominator of exactly 1.0, so both modes have equal latency.
// Reset clears all valid bits and loads the identity matrix. When a result waits
// with out_ready low the whole pipeline holds; one extra point is caught in an
// input skid register, after which in_ready drops until the pipeline moves again.
module projective_point_transform_core #(
	parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ppt_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ppt_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int COORD_W = ppt_pkg::COORD_W;
	localparam int NUM_W   = ppt_pkg::NUM_W;
	localparam int Q_W     = ppt_pkg::Q_W;
	localparam int DIV_LAT = ppt_pkg::DIV_LAT;
	localparam int PIPE_N  = 2 + DIV_LAT;

	localparam logic [COORD_W-1:0]      ONE_Q     = COORD_W'(1) << FRAC_BITS;
	localparam logic signed [NUM_W-1:0] DEN_ONE   = NUM_W'(1) << (2 * FRAC_BITS);
	localparam logic [Q_W:0]            LIM_NEG   = (Q_W + 1)'(1) << (COORD_W - 1);
	localparam logic [Q_W:0]            LIM_POS   = LIM_NEG - (Q_W + 1)'(1);

	logic signed [COORD_W-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m22_q;
	logic [2*COORD_W-1:0]      pxy_q;

	logic                      skid_vld_q;
	ppt_pkg::in_item_t         skid_q;
	logic                      head_valid;
	ppt_pkg::in_item_t         head_data;
	logic                      en;

	logic [PIPE_N-1:0]         stage_vld_q;
	logic                      cmd_s1, cmd_s2;
	logic [DIV_LAT-1:0]        dbz_s;

	logic signed [NUM_W-1:0]   nx_sum, ny_sum, w_sum, den_sel;
	logic                      dbz_in;
	ppt_pkg::div_res_t         res_x, res_y;

	logic                      out_valid_q;
	ppt_pkg::out_item_t        out_q;
	ppt_pkg::out_item_t        out_next;
	logic [COORD_W:0]          cl_x, cl_y;

	// Clamp a rounded magnitude to the signed range and apply its sign.
	// Returns {saturated, value}.
	function automatic logic [COORD_W:0] clamp(ppt_pkg::div_res_t r);
		logic [Q_W:0]     lim;
		logic             sat;
		logic [Q_W:0]     mag;
		logic [COORD_W-1:0] val;
		lim = r.neg ? LIM_NEG : LIM_POS;
		sat = r.ovf || (r.quo > lim);
		mag = sat ? lim : r.quo;
		val = mag[COORD_W-1:0];
		return {sat, (r.neg ? (~val + COORD_W'(1)) : val)};
	endfunction

	// Configuration registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m00_q <= ONE_Q;
			m01_q <= '0;
			m02_q <= '0;
			m10_q <= '0;
			m11_q <= ONE_Q;
			m12_q <= '0;
			pxy_q <= '0;
			m22_q <= ONE_Q;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ppt_pkg::cfg_reg_t'(cfg_index))
				ppt_pkg::REG_M00:            m00_q <= cfg_data[COORD_W-1:0];
				ppt_pkg::REG_M01:            m01_q <= cfg_data[COORD_W-1:0];
				ppt_pkg::REG_M02:            m02_q <= cfg_data[COORD_W-1:0];
				ppt_pkg::REG_M10:            m10_q <= cfg_data[COORD_W-1:0];
				ppt_pkg::REG_M11:            m11_q <= cfg_data[COORD_W-1:0];
				ppt_pkg::REG_M12:            m12_q <= cfg_data[COORD_W-1:0];
				ppt_pkg::REG_PERSPECTIVE_XY: pxy_q <= cfg_data;
				ppt_pkg::REG_M22:            m22_q <= cfg_data[COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The pipeline advances whenever the output register is free or being read.
	assign en = !out_valid_q || out_ready;

	// Input skid register catches a transaction taken while the pipeline holds.
	assign in_ready   = !skid_vld_q;
	assign head_valid = skid_vld_q || in_valid;
	assign head_data  = skid_vld_q ? skid_q : in_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && in_ready) begin
			skid_q <= in_data;
		end
	end

	// Valid bits travel with the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[PIPE_N-2:0], head_valid};
		end
	end

	// Command follows the linear-form stages.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= head_data.cmd;
			cmd_s2 <= cmd_s1;
		end
	end

	// Two numerators and the denominator.
	ppt_lin #(.FRAC_BITS(FRAC_BITS)) u_lin_x (
		.clk (clk),
		.en  (en),
		.x   (head_data.x_in),
		.y   (head_data.y_in),
		.c0  (m00_q),
		.c1  (m01_q),
		.c2  (m02_q),
		.sum (nx_sum)
	);

	ppt_lin #(.FRAC_BITS(FRAC_BITS)) u_lin_y (
		.clk (clk),
		.en  (en),
		.x   (head_data.x_in),
		.y   (head_data.y_in),
		.c0  (m10_q),
		.c1  (m11_q),
		.c2  (m12_q),
		.sum (ny_sum)
	);

	ppt_lin #(.FRAC_BITS(FRAC_BITS)) u_lin_w (
		.clk (clk),
		.en  (en),
		.x   (head_data.x_in),
		.y   (head_data.y_in),
		.c0  (pxy_q[COORD_W-1:0]),
		.c1  (pxy_q[2*COORD_W-1:COORD_W]),
		.c2  (m22_q),
		.sum (w_sum)
	);

	// Affine mode divides by exactly 1.0 in Q(2F).
	assign den_sel = (cmd_s2 == ppt_pkg::CMD_PROJECTIVE) ? w_sum : DEN_ONE;
	assign dbz_in  = (cmd_s2 == ppt_pkg::CMD_PROJECTIVE) && (w_sum == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			dbz_s <= {dbz_s[DIV_LAT-2:0], dbz_in};
		end
	end

	ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (nx_sum),
		.den (den_sel),
		.res (res_x)
	);

	ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (ny_sum),
		.den (den_sel),
		.res (res_y)
	);

	// Saturation, sign and the zero-denominator override.
	always_comb begin
		cl_x = clamp(res_x);
		cl_y = clamp(res_y);
		if (dbz_s[DIV_LAT-1]) begin
			out_next.x_out       = '0;
			out_next.y_out       = '0;
			out_next.div_by_zero = 1'b1;
			out_next.saturated   = 1'b0;
		end else begin
			out_next.x_out       = cl_x[COORD_W-1:0];
			out_next.y_out       = cl_y[COORD_W-1:0];
			out_next.div_by_zero = 1'b0;
			out_next.saturated   = cl_x[COORD_W] || cl_y[COORD_W];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= stage_vld_q[PIPE_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: src/ppt_lin.sv
`timescale 1ns / 1ps
// Two-stage linear form c0*x + c1*y + (c2 << FRAC_BITS), exact.
// Depends on ppt_pkg for widths.
module ppt_lin #(
	parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [ppt_pkg::COORD_W-1:0]     x,
	input  logic signed [ppt_pkg::COORD_W-1:0]     y,
	input  logic signed [ppt_pkg::COORD_W-1:0]     c0,
	input  logic signed [ppt_pkg::COORD_W-1:0]     c1,
	input  logic signed [ppt_pkg::COORD_W-1:0]     c2,
	output logic signed [ppt_pkg::NUM_W-1:0]       sum
);

	localparam int PROD_W = 2 * ppt_pkg::COORD_W;

	logic signed [PROD_W-1:0]           p0_s1;
	logic signed [PROD_W-1:0]           p1_s1;
	logic signed [ppt_pkg::COORD_W-1:0] c2_s1;
	logic signed [ppt_pkg::NUM_W-1:0]   sum_s2;

	// Stage 1: the two products.
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PROD_W'(x) * PROD_W'(c0);
			p1_s1 <= PROD_W'(y) * PROD_W'(c1);
			c2_s1 <= c2;
		end
	end

	// Stage 2: sign-extended sum with the scaled constant term.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= ppt_pkg::NUM_W'(p0_s1) + ppt_pkg::NUM_W'(p1_s1)
				+ (ppt_pkg::NUM_W'(c2_s1) <<< FRAC_BITS);
		end
	end

	assign sum = sum_s2;

endmodule

FILE: src/ppt_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: round(|num| * 2^F / |den|), one quotient bit per stage.
// Depends on ppt_pkg for widths and the div_res_t result struct.
module ppt_div #(
	parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ppt_pkg::NUM_W-1:0]  num,
	input  logic signed [ppt_pkg::NUM_W-1:0]  den,
	output ppt_pkg::div_res_t                 res
);

	localparam int NUM_W = ppt_pkg::NUM_W;
	localparam int Q_W   = ppt_pkg::Q_W;
	localparam int R_W   = NUM_W + Q_W;

	logic               neg_s1;
	logic [NUM_W-1:0]   nmag_s1;
	logic [NUM_W-1:0]   dmag_s1;

	logic [R_W-1:0]     dvd;
	logic [R_W-1:0]     dlim;

	logic [R_W-1:0]     rem_s  [Q_W+1];
	logic [NUM_W-1:0]   dsr_s  [Q_W+1];
	logic [Q_W-1:0]     quo_s  [Q_W+1];
	logic               neg_s  [Q_W+1];
	logic               ovf_s  [Q_W+1];

	logic [R_W-1:0]     trial  [Q_W];
	logic               ge     [Q_W];

	logic               rnd;
	ppt_pkg::div_res_t  rnd_s;

	// Magnitudes and result sign.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= num[NUM_W-1] ^ den[NUM_W-1];
			nmag_s1 <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			dmag_s1 <= den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
		end
	end

	// Dividend and the check for a quotient of 2^Q_W or more.
	assign dvd  = R_W'(nmag_s1) << FRAC_BITS;
	assign dlim = R_W'(dmag_s1) << Q_W;

	// Trial subtraction for each quotient bit, most significant first.
	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			trial[k] = R_W'(dsr_s[k]) << (Q_W - 1 - k);
			ge[k]    = rem_s[k] >= trial[k];
		end
	end

	// Dividend stage followed by the quotient bit stages.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dvd;
			dsr_s[0] <= dmag_s1;
			quo_s[0] <= '0;
			neg_s[0] <= neg_s1;
			ovf_s[0] <= dvd >= dlim;
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k+1] <= ge[k] ? rem_s[k] - trial[k] : rem_s[k];
				dsr_s[k+1] <= dsr_s[k];
				quo_s[k+1] <= {quo_s[k][Q_W-2:0], ge[k]};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// Round to nearest, ties away from zero, on the magnitude.
	assign rnd = {rem_s[Q_W], 1'b0} >= (R_W + 1)'(dsr_s[Q_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s.neg <= neg_s[Q_W];
			rnd_s.ovf <= ovf_s[Q_W];
			rnd_s.quo <= (Q_W + 1)'(quo_s[Q_W]) + (Q_W + 1)'(rnd);
		end
	end

	assign res = rnd_s;

endmodule

FILE: src/ppt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for projective_point_transform_core, attached by bind.
// Depends on ppt_pkg and projective_point_transform_core.
module ppt_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  ppt_pkg::out_item_t              out_data
);

	// A stalled result holds until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output transaction changed or dropped");

	// A zero denominator never reports saturation.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_by_zero |-> !out_data.saturated)
		else $error("div_by_zero and saturated both set");

	// A zero denominator gives the origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_by_zero |->
			out_data.x_out == '0 && out_data.y_out == '0)
		else $error("div_by_zero result is not zero");

	// The input side only closes after it has just taken a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready dropped without an input transaction");

endmodule

bind projective_point_transform_core ppt_checker u_ppt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: bench/tb_projective_point_transform_core.sv
`timescale 1ns / 1ps
// Self-checking bench for projective_point_transform_core: directed table, then random matrices.
// Depends on src/ppt_pkg.sv and the core; untyped expectations come from a local predictor.
module tb_projective_point_transform_core;

	typedef ppt_pkg::in_item_t  in_item_t;
	typedef ppt_pkg::out_item_t out_item_t;
	typedef ppt_pkg::cfg_reg_t  cfg_reg_t;

	localparam int FRAC            = ppt_pkg::FRAC_BITS_DEF;
	localparam int IDX_W           = ppt_pkg::CFG_IDX_W;
	localparam int DATA_W          = ppt_pkg::CFG_DATA_W;
	localparam logic CMD_AFF       = ppt_pkg::CMD_AFFINE;
	localparam logic CMD_PROJ      = ppt_pkg::CMD_PROJECTIVE;
	localparam int NUM_REGS        = 8;
	localparam int N_PHASES        = 12;
	localparam int POINTS_PER_PHASE = 70;
	localparam int DRAIN_CYCLES    = 60;
	localparam int unsigned CYCLE_LIMIT = 200_000;

	localparam logic [31:0] Q_ONE     = 32'h0001_0000;
	localparam logic [31:0] Q_TWO     = 32'h0002_0000;
	localparam logic [31:0] Q_HALF    = 32'h0000_8000;
	localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
	localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN     = 32'h8000_0000;
	localparam logic [31:0] CORNER_VALUES [7] = '{Q_MAX, Q_MIN, 32'd0, Q_ONE, Q_NEG_ONE,
		32'd1, 32'hFFFF_FFFF};
	localparam out_item_t NO_RESULT = '0;

	typedef enum int {MIX_SMALL, MIX_FULL, MIX_CORNER, MIX_ANY, MIX_VANISHING} matrix_mix_t;
	typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;

	// One row of the directed table: either a register write or a point.
	typedef struct {
		row_kind_t   kind;
		cfg_reg_t    target;
		logic [63:0] value;
		in_item_t    point;
		logic        typed;
		out_item_t   result;
	} stim_row_t;

	// Result typed into the table for a point, if any.
	typedef struct {
		logic      typed;
		out_item_t result;
	} table_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	logic [63:0] matrix_regs [NUM_REGS];
	out_item_t pending_transforms [$];
	table_result_t table_results [$];
	stim_row_t directed_rows [$];

	bit calm = 1'b0;
	int unsigned cycle_count = 0;
	int mismatches = 0;
	int points_sent = 0;
	int results_seen = 0;
	int zero_den_seen = 0;
	int clamped_seen = 0;

	projective_point_transform_core #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Global watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Watchdog expired after %0d cycles.", cycle_count);
			$display("tb_projective_point_transform_core NOT OK");
			$finish;
		end
	end

	// Exact c0*x + c1*y + (c2 << F) in a wide signed accumulator.
	function automatic logic signed [95:0] affine_sum(input logic signed [31:0] c0, c1, c2,
			input logic signed [31:0] px, py);
		logic signed [95:0] a0, a1, a2, ax, ay;
		a0 = c0;
		a1 = c1;
		a2 = c2;
		ax = px;
		ay = py;
		return a0 * ax + a1 * ay + (a2 <<< FRAC);
	endfunction

	// Rounds num * 2^F / den half away from zero and clamps to 32 bits.
	// Returns the clamp flag in the top bit.
	function automatic logic [32:0] scaled_quotient(input logic signed [95:0] num, den);
		logic neg;
		logic signed [95:0] num_mag, den_mag;
		logic [191:0] dividend, divisor, quo, rem, limit;
		logic clamp;
		neg = num[95] ^ den[95];
		num_mag = num[95] ? -num : num;
		den_mag = den[95] ? -den : den;
		dividend = {96'd0, num_mag} << FRAC;
		divisor = {96'd0, den_mag};
		quo = dividend / divisor;
		rem = dividend % divisor;
		if ((rem << 1) >= divisor)
			quo = quo + 1;
		limit = neg ? {160'd0, Q_MIN} : {160'd0, Q_MAX};
		clamp = 1'b0;
		if (quo > limit) begin
			clamp = 1'b1;
			quo = limit;
		end
		return {clamp, neg ? 32'd0 - quo[31:0] : quo[31:0]};
	endfunction

	// Predicted result of one point under the mirrored matrix.
	function automatic out_item_t transform_point(input in_item_t pt);
		logic signed [95:0] num_x, num_y, den;
		logic [32:0] qx, qy;
		out_item_t r;
		num_x = affine_sum(matrix_regs[ppt_pkg::REG_M00][31:0],
			matrix_regs[ppt_pkg::REG_M01][31:0],
			matrix_regs[ppt_pkg::REG_M02][31:0], pt.x_in, pt.y_in);
		num_y = affine_sum(matrix_regs[ppt_pkg::REG_M10][31:0],
			matrix_regs[ppt_pkg::REG_M11][31:0],
			matrix_regs[ppt_pkg::REG_M12][31:0], pt.x_in, pt.y_in);
		r = '0;
		if (pt.cmd == CMD_PROJ) begin
			den = affine_sum(matrix_regs[ppt_pkg::REG_PERSPECTIVE_XY][31:0],
				matrix_regs[ppt_pkg::REG_PERSPECTIVE_XY][63:32],
				matrix_regs[ppt_pkg::REG_M22][31:0], pt.x_in, pt.y_in);
			if (den == 0) begin
				r.div_by_zero = 1'b1;
				return r;
			end
		end else begin
			den = 96'sd1 <<< (2 * FRAC);
		end
		qx = scaled_quotient(num_x, den);
		qy = scaled_quotient(num_y, den);
		r.x_out = qx[31:0];
		r.y_out = qy[31:0];
		r.saturated = qx[32] | qy[32];
		return r;
	endfunction

	// Mirror the matrix, record expectations at input transactions and check outputs.
	always @(posedge clk) begin : scoreboard
		out_item_t want;
		table_result_t row;
		if (!arst_n) begin
			matrix_regs[ppt_pkg::REG_M00] = {32'd0, Q_ONE};
			matrix_regs[ppt_pkg::REG_M01] = '0;
			matrix_regs[ppt_pkg::REG_M02] = '0;
			matrix_regs[ppt_pkg::REG_M10] = '0;
			matrix_regs[ppt_pkg::REG_M11] = {32'd0, Q_ONE};
			matrix_regs[ppt_pkg::REG_M12] = '0;
			matrix_regs[ppt_pkg::REG_PERSPECTIVE_XY] = '0;
			matrix_regs[ppt_pkg::REG_M22] = {32'd0, Q_ONE};
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
				matrix_regs[cfg_index] = (cfg_index == ppt_pkg::REG_PERSPECTIVE_XY) ?
					cfg_data : {32'd0, cfg_data[31:0]};
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.div_by_zero)
					zero_den_seen++;
				if (out_data.saturated)
					clamped_seen++;
				if (pending_transforms.size() == 0) begin
					$error("Output transaction with no result expected: x_out %0d y_out %0d",
						out_data.x_out, out_data.y_out);
					mismatches++;
				end else begin
					want = pending_transforms.pop_front();
					if (out_data.x_out !== want.x_out) begin
						$error("x_out: expected %0d, got %0d", want.x_out, out_data.x_out);
						mismatches++;
					end
					if (out_data.y_out !== want.y_out) begin
						$error("y_out: expected %0d, got %0d", want.y_out, out_data.y_out);
						mismatches++;
					end
					if (out_data.div_by_zero !== want.div_by_zero) begin
						$error("div_by_zero: expected %0b, got %0b", want.div_by_zero,
							out_data.div_by_zero);
						mismatches++;
					end
					if (out_data.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated,
							out_data.saturated);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				row.typed = 1'b0;
				if (table_results.size() != 0)
					row = table_results.pop_front();
				want = row.typed ? row.result : transform_point(in_data);
				pending_transforms = {pending_transforms, want};
			end
		end
	end

	// Output side: random stalls before each result unless the run is calm.
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic stim_row_t cfg_row(input cfg_reg_t target, input logic [63:0] value);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.target = target;
		row.value = value;
		row.point = '0;
		row.typed = 1'b0;
		row.result = NO_RESULT;
		return row;
	endfunction

	function automatic stim_row_t pt_row(input logic cmd, input logic [31:0] px, py,
			input logic typed, input out_item_t result);
		stim_row_t row;
		row.kind = ROW_POINT;
		row.target = ppt_pkg::REG_M00;
		row.value = '0;
		row.point.cmd = cmd;
		row.point.x_in = px;
		row.point.y_in = py;
		row.typed = typed;
		row.result = result;
		return row;
	endfunction

	// One point transaction after a random gap unless the run is calm; valid stays high between back-to-back points.
	task automatic send_point(input in_item_t pt, input logic typed, input out_item_t result);
		int gap;
		table_result_t row;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row.typed = typed;
		row.result = result;
		table_results = {table_results, row};
		in_valid <= 1'b1;
		in_data <= pt;
		do @(posedge clk); while (!in_ready);
		points_sent++;
	endtask

	// Stop sending and wait until every outstanding result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_transforms.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] draw_coef(input matrix_mix_t mix);
		matrix_mix_t pick;
		pick = mix;
		if (mix == MIX_ANY)
			pick = matrix_mix_t'($urandom_range(MIX_SMALL, MIX_CORNER));
		case (pick)
			MIX_FULL:   return $urandom;
			MIX_CORNER: return CORNER_VALUES[$urandom_range(0, 6)];
			default:    return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		endcase
	endfunction

	// Coordinates: mostly moderate values, some full range, some corners.
	function automatic logic [31:0] draw_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		else if (pick < 9)
			return $urandom;
		return CORNER_VALUES[$urandom_range(0, 6)];
	endfunction

	// Main stimulus.
	initial begin : stimulus
		int k;
		int phase;
		int i;
		int r;
		int settings;
		matrix_mix_t mix;
		logic [31:0] m22_val;
		logic [63:0] value;
		in_item_t pt;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: identity after reset, zero denominators, clamping,
		// rounding ties, negative denominator and full-scale coefficients.
		directed_rows = {
			pt_row(CMD_AFF, 32'd0, 32'd0, 1'b1, out_item_t'{32'd0, 32'd0, 1'b0, 1'b0}),
			pt_row(CMD_AFF, Q_MAX, Q_MIN, 1'b1, out_item_t'{Q_MAX, Q_MIN, 1'b0, 1'b0}),
			pt_row(CMD_PROJ, Q_MIN, Q_MAX, 1'b1, out_item_t'{Q_MIN, Q_MAX, 1'b0, 1'b0}),
			pt_row(CMD_PROJ, Q_ONE, Q_NEG_ONE, 1'b1,
				out_item_t'{Q_ONE, Q_NEG_ONE, 1'b0, 1'b0}),
			cfg_row(ppt_pkg::REG_M22, 64'd0),
			pt_row(CMD_PROJ, 32'd3, 32'd5, 1'b1, out_item_t'{32'd0, 32'd0, 1'b1, 1'b0}),
			pt_row(CMD_AFF, 32'd7, -32'sd9, 1'b1, out_item_t'{32'd7, -32'sd9, 1'b0, 1'b0}),
			pt_row(CMD_PROJ, Q_MIN, Q_MIN, 1'b1, out_item_t'{32'd0, 32'd0, 1'b1, 1'b0}),
			cfg_row(ppt_pkg::REG_M00, {32'd0, Q_MAX}),
			cfg_row(ppt_pkg::REG_M01, {32'd0, Q_MAX}),
			cfg_row(ppt_pkg::REG_M02, {32'd0, Q_MAX}),
			pt_row(CMD_AFF, Q_MAX, Q_MAX, 1'b1, out_item_t'{Q_MAX, Q_MAX, 1'b0, 1'b1}),
			pt_row(CMD_AFF, Q_MIN, Q_MIN, 1'b1, out_item_t'{Q_MIN, Q_MIN, 1'b0, 1'b1}),
			cfg_row(ppt_pkg::REG_M00, {32'd0, Q_MIN}),
			cfg_row(ppt_pkg::REG_M01, {32'd0, Q_MIN}),
			cfg_row(ppt_pkg::REG_M02, {32'd0, Q_MIN}),
			pt_row(CMD_AFF, Q_MIN, Q_MIN, 1'b1, out_item_t'{Q_MAX, Q_MIN, 1'b0, 1'b1}),
			pt_row(CMD_PROJ, Q_MAX, Q_MAX, 1'b1, out_item_t'{32'd0, 32'd0, 1'b1, 1'b0}),
			cfg_row(ppt_pkg::REG_M00, {32'd0, Q_HALF}),
			cfg_row(ppt_pkg::REG_M01, 64'd0),
			cfg_row(ppt_pkg::REG_M02, 64'd0),
			cfg_row(ppt_pkg::REG_M22, {32'd0, Q_ONE}),
			pt_row(CMD_AFF, 32'd1, 32'd0, 1'b1, out_item_t'{32'd1, 32'd0, 1'b0, 1'b0}),
			pt_row(CMD_AFF, -32'sd1, 32'd0, 1'b1, out_item_t'{-32'sd1, 32'd0, 1'b0, 1'b0}),
			pt_row(CMD_AFF, 32'd3, 32'd0, 1'b1, out_item_t'{32'd2, 32'd0, 1'b0, 1'b0}),
			cfg_row(ppt_pkg::REG_PERSPECTIVE_XY, {32'd0, Q_ONE}),
			cfg_row(ppt_pkg::REG_M22, {32'd0, Q_NEG_ONE}),
			pt_row(CMD_PROJ, Q_ONE, 32'd0, 1'b1, out_item_t'{32'd0, 32'd0, 1'b1, 1'b0}),
			pt_row(CMD_PROJ, Q_TWO, 32'd0, 1'b1, out_item_t'{Q_ONE, 32'd0, 1'b0, 1'b0}),
			pt_row(CMD_PROJ, 32'd0, Q_ONE, 1'b1,
				out_item_t'{32'd0, Q_NEG_ONE, 1'b0, 1'b0}),
			cfg_row(ppt_pkg::REG_PERSPECTIVE_XY, {Q_MIN, Q_MAX}),
			cfg_row(ppt_pkg::REG_M10, {32'd0, Q_MAX}),
			cfg_row(ppt_pkg::REG_M11, {32'd0, Q_NEG_ONE}),
			cfg_row(ppt_pkg::REG_M12, {32'd0, Q_MIN}),
			pt_row(CMD_PROJ, 32'h0012_3456, 32'hFFED_CBA9, 1'b0, NO_RESULT),
			pt_row(CMD_AFF, 32'h7FFF_0000, 32'h0000_8000, 1'b0, NO_RESULT),
			pt_row(CMD_PROJ, Q_NEG_ONE, Q_ONE, 1'b0, NO_RESULT)
		};
		settings = 1;
		for (k = 0; k < directed_rows.size(); k++) begin
			if (directed_rows[k].kind == ROW_CFG) begin
				if (k == 0 || directed_rows[k - 1].kind != ROW_CFG)
					settings++;
				wait_drained();
				write_reg(directed_rows[k].target, directed_rows[k].value);
			end else begin
				send_point(directed_rows[k].point, directed_rows[k].typed,
					directed_rows[k].result);
			end
		end
		wait_drained();

		// Random phases, each with a fresh matrix written while the core is idle.
		for (phase = 0; phase < N_PHASES; phase++) begin
			mix = matrix_mix_t'(phase % 5);
			calm = (phase == 5);
			wait_drained();
			for (r = 0; r < NUM_REGS; r++) begin
				if (r == ppt_pkg::REG_PERSPECTIVE_XY)
					value = (mix == MIX_VANISHING) ? {32'd0, Q_ONE} :
						{draw_coef(mix), draw_coef(mix)};
				else if (r == ppt_pkg::REG_M22 && mix == MIX_VANISHING)
					value = {$urandom, draw_coef(MIX_SMALL)};
				else
					value = {$urandom, draw_coef(mix)};
				if (r == ppt_pkg::REG_M22)
					m22_val = value[31:0];
				write_reg(cfg_reg_t'(r), value);
			end
			// A write to an unused index must leave the matrix alone.
			write_reg(IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1)),
				{$urandom, $urandom});
			settings++;
			for (i = 0; i < POINTS_PER_PHASE; i++) begin
				if (phase == 2 && i == POINTS_PER_PHASE / 2)
					wait_drained();
				pt.cmd = ($urandom_range(0, 1) == 0) ? CMD_AFF : CMD_PROJ;
				pt.x_in = draw_coord();
				pt.y_in = draw_coord();
				// With m20 = 1.0 and m21 = 0 the denominator vanishes at x = -m22.
				if (mix == MIX_VANISHING && pt.cmd == CMD_PROJ &&
						$urandom_range(0, 3) == 0)
					pt.x_in = 32'd0 - m22_val;
				send_point(pt, 1'b0, NO_RESULT);
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d points over %0d matrix settings; %0d results checked, %0d mismatches.",
			points_sent, settings, results_seen, mismatches);
		$display("Results with a zero denominator: %0d; results clamped to range: %0d.",
			zero_den_seen, clamped_seen);
		if (mismatches == 0 && pending_transforms.size() == 0)
			$display("tb_projective_point_transform_core OK");
		else
			$display("tb_projective_point_transform_core NOT OK");
		$finish;
	end

endmodule
